// File: rtl/core/tqa_pkg.sv
// Shared constants and types for the two-queues-in-one-array unit.
// Depends on nothing; tqa_if, tqa_ctrl, tqa_dp and the top level import it.
`default_nettype none

package tqa_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;

    localparam logic [1:0] REQ_ENQ_ONE = 2'd0;
    localparam logic [1:0] REQ_DEQ_ONE = 2'd1;
    localparam logic [1:0] REQ_ENQ_TWO = 2'd2;
    localparam logic [1:0] REQ_DEQ_TWO = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic accept;
    } tqa_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/tqa_if.sv
// Request and response channel interfaces of the two-queues-in-one-array unit.
// Depends on tqa_pkg for the payload width.
`default_nettype none

interface tqa_req_if
    import tqa_pkg::*;
    ;
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] data_value;

    modport source (output valid, output req_type, output data_value, input ready);
    modport sink (input valid, input req_type, input data_value, output ready);
endinterface

interface tqa_rsp_if
    import tqa_pkg::*;
    ;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic                     store_full;
    logic                     first_empty;
    logic                     second_empty;

    modport source (output valid, output status, output read_value, output store_full,
                    output first_empty, output second_empty, input ready);
    modport sink (input valid, input status, input read_value, input store_full,
                  input first_empty, input second_empty, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tqa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module tqa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tqa_ctrl.sv
// Handshake controller of the two-queues-in-one-array unit.
// Depends on tqa_pkg for the command struct.
`default_nettype none

module tqa_ctrl
    import tqa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output tqa_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_HOLD = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        req_ready  = (state_reg == S_IDLE) || rsp_ready;
        rsp_valid  = (state_reg == S_HOLD);
        cmd.accept = req_valid && req_ready;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (!cmd.accept && rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tqa_dp.sv
// Pointer logic, result registers and slot store of the two-queues-in-one-array unit.
// Depends on tqa_pkg and tqa_ram.
`default_nettype none

module tqa_dp
    import tqa_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire tqa_cmd_t                 cmd,
    input  wire logic [1:0]               req_type,
    input  wire logic signed [DATA_W-1:0] data_value,
    output logic      [1:0]               status,
    output logic signed [DATA_W-1:0]      read_value,
    output logic                          store_full,
    output logic                          first_empty,
    output logic                          second_empty
);

    localparam int PW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam logic [PW-1:0] P_ZERO = PW'(0);
    localparam logic [PW-1:0] P_ONE  = PW'(1);
    localparam logic [PW-1:0] P_TOP  = PW'(DEPTH);
    localparam logic [PW-1:0] P_LAST = PW'(DEPTH - 1);

    // Queue one pointers are kept offset by one so that zero means empty.
    logic [PW-1:0] lo_head_reg, lo_head_next;
    logic [PW-1:0] lo_tail_reg, lo_tail_next;
    logic [PW-1:0] hi_head_reg, hi_head_next;
    logic [PW-1:0] hi_tail_reg, hi_tail_next;

    logic [1:0]    status_reg, status_next;
    logic          deq_ok_reg, deq_ok_next;
    logic          full_reg, e1_reg, e2_reg;

    logic              full_now;
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [DATA_W-1:0] rd_data;

    always_comb
    begin
        lo_head_next = lo_head_reg;
        lo_tail_next = lo_tail_reg;
        hi_head_next = hi_head_reg;
        hi_tail_next = hi_tail_reg;
        status_next  = ST_DONE;
        deq_ok_next  = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        wr_addr      = '0;
        rd_addr      = '0;
        full_now     = (lo_tail_reg == hi_tail_reg);
        case (req_type)
            REQ_ENQ_ONE:
            begin
                if (full_now)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    if (lo_head_reg == P_ZERO)
                    begin
                        lo_head_next = P_ONE;
                        lo_tail_next = P_ONE;
                    end
                    else
                    begin
                        lo_tail_next = lo_tail_reg + P_ONE;
                    end
                    wr_en   = 1'b1;
                    wr_addr = AW'(lo_tail_next - P_ONE);
                end
            end
            REQ_DEQ_ONE:
            begin
                if (lo_head_reg == P_ZERO)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    deq_ok_next = 1'b1;
                    rd_en       = 1'b1;
                    rd_addr     = AW'(lo_head_reg - P_ONE);
                    if (lo_head_reg == lo_tail_reg)
                    begin
                        lo_head_next = P_ZERO;
                        lo_tail_next = P_ZERO;
                    end
                    else
                    begin
                        lo_head_next = lo_head_reg + P_ONE;
                    end
                end
            end
            REQ_ENQ_TWO:
            begin
                if (full_now)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    if (hi_head_reg == P_TOP)
                    begin
                        hi_head_next = P_LAST;
                        hi_tail_next = P_LAST;
                    end
                    else
                    begin
                        hi_tail_next = hi_tail_reg - P_ONE;
                    end
                    wr_en   = 1'b1;
                    wr_addr = AW'(hi_tail_next);
                end
            end
            REQ_DEQ_TWO:
            begin
                if (hi_head_reg == P_TOP)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    deq_ok_next = 1'b1;
                    rd_en       = 1'b1;
                    rd_addr     = AW'(hi_head_reg);
                    if (hi_head_reg == hi_tail_reg)
                    begin
                        hi_head_next = P_TOP;
                        hi_tail_next = P_TOP;
                    end
                    else
                    begin
                        hi_head_next = hi_head_reg - P_ONE;
                    end
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_head_reg <= P_ZERO;
            lo_tail_reg <= P_ZERO;
            hi_head_reg <= P_TOP;
            hi_tail_reg <= P_TOP;
        end
        else if (cmd.accept)
        begin
            lo_head_reg <= lo_head_next;
            lo_tail_reg <= lo_tail_next;
            hi_head_reg <= hi_head_next;
            hi_tail_reg <= hi_tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            status_reg <= status_next;
            deq_ok_reg <= deq_ok_next;
            full_reg   <= (lo_tail_next == hi_tail_next);
            e1_reg     <= (lo_head_next == P_ZERO);
            e2_reg     <= (hi_head_next == P_TOP);
        end
    end

    tqa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (cmd.accept && wr_en),
        .wr_addr (wr_addr),
        .wr_data (data_value),
        .rd_en   (cmd.accept && rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign status       = status_reg;
    assign read_value   = deq_ok_reg ? $signed(rd_data) : '0;
    assign store_full   = full_reg;
    assign first_empty  = e1_reg;
    assign second_empty = e2_reg;

    a_tails_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        lo_tail_reg <= hi_tail_reg)
        else $error("queue one rear passed queue two rear");

    a_one_order: assert property (@(posedge clk) disable iff (!rst_n)
        (lo_head_reg <= lo_tail_reg) && ((lo_head_reg == P_ZERO) == (lo_tail_reg == P_ZERO)))
        else $error("queue one pointers inconsistent");

    a_two_order: assert property (@(posedge clk) disable iff (!rst_n)
        (hi_head_reg >= hi_tail_reg) && ((hi_head_reg == P_TOP) == (hi_tail_reg == P_TOP)))
        else $error("queue two pointers inconsistent");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && full_now && (req_type == REQ_ENQ_ONE || req_type == REQ_ENQ_TWO)
        |=> status_reg == ST_OVERFLOW && $stable(lo_tail_reg) && $stable(hi_tail_reg))
        else $error("enqueue into a full store was not refused");

endmodule

`default_nettype wire

// File: rtl/core/two_queues_one_array_unit.sv
// Top level of the two-queues-in-one-array unit: controller, datapath and channel ports.
// Depends on tqa_pkg, tqa_if, tqa_ctrl and tqa_dp.
`default_nettype none

// Two FIFO queues share one store of DEPTH 32-bit slots: queue one fills upward from
// the bottom, queue two downward from the top, and a slot is reused only after its
// queue has drained to empty. Each request beat yields exactly one response beat with
// a status, the dequeued value and the full and empty flags. A request is processed in
// the cycle it is accepted: the pointers update, the slot RAM is written or read and the
// response is captured in the output registers, all at that edge. A new request is
// accepted in the same cycle the pending response is taken, so the unit sustains one
// beat per cycle when the sink is always ready. No clearing pass is needed after reset.
module two_queues_one_array_unit
    import tqa_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tqa_req_if.sink    req,
    tqa_rsp_if.source  rsp
);

    tqa_cmd_t cmd;

    tqa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    tqa_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req_type     (req.req_type),
        .data_value   (req.data_value),
        .status       (rsp.status),
        .read_value   (rsp.read_value),
        .store_full   (rsp.store_full),
        .first_empty  (rsp.first_empty),
        .second_empty (rsp.second_empty)
    );

endmodule

`default_nettype wire
